// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the circle point and derivatives block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal holds while a channel is stalled.
`define CPD_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
    `CPD_ASSERT(label, clk, rst_n, (vld && !rdy) |=> $stable(sig), msg)

`endif

// ===== design/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg
// Constants and types shared by the circle point and derivatives block.
// ----------------------------------------------------------------------------
package cpd_pkg;

    // Derivative order field width
    localparam int ORDER_W = 3;

    // CORDIC datapath widths (Q30 vector, 33-bit residual angle)
    localparam int XW        = 32;
    localparam int ZW        = 33;
    localparam int FRAC_BITS = 30;
    localparam int TURN_W    = 32;
    localparam int ATAN_LEN  = 32;

    typedef logic signed [XW-1:0] t_xy;
    typedef logic signed [ZW-1:0] t_z;

    // CORDIC start vector gain, Q30
    localparam t_xy CORDIC_GAIN = 32'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn
    localparam logic [TURN_W-1:0] ATAN_TURN32 [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLICIT_MODE = 2'd1;

    // Explicit derivation mode code
    localparam logic DERIVATION_EXPLICIT = 1'b1;

endpackage

// ===== design/cpd_if.sv =====
// ----------------------------------------------------------------------------
// cpd_if
// Handshake channels of the circle point and derivatives block.
// ----------------------------------------------------------------------------

// Input channel: one angle and a highest order per item
interface cpd_in_if
    import cpd_pkg::*;
#(
    parameter int ANGLE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] angle;
    logic [ORDER_W-1:0]    max_order;

    modport source (output valid, angle, max_order, input ready);
    modport sink   (input valid, angle, max_order, output ready);
endinterface

// Result channel: one derivative order per item
interface cpd_out_if
    import cpd_pkg::*;
#(
    parameter int DATA_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic [ORDER_W-1:0]          order;
    logic signed [DATA_BITS-1:0] x_value;
    logic signed [DATA_BITS-1:0] y_value;
    logic                        last;

    modport source (output valid, order, x_value, y_value, last, input ready);
    modport sink   (input valid, order, x_value, y_value, last, output ready);
endinterface

// Configuration write channel
interface cpd_cfg_if
    import cpd_pkg::*;
#(
    parameter int DATA_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/circle_point_and_derivatives_unit.sv =====
// ----------------------------------------------------------------------------
// circle_point_and_derivatives_unit
// Pipelined CORDIC evaluation of a circle point and its angle derivatives.
// ----------------------------------------------------------------------------
// Each input item carries an angle (unsigned fraction of a full turn) and a
// highest order. The block returns r*(cos, sin) for order 0 and the same
// vector turned by k quarter turns for order k, up to max_order when
// explicit mode is set, else only the point; the final result is flagged
// with last. Outputs are signed, in the radius format, and saturate. The
// datapath is CORDIC_STAGES rotation stages (capped at 32), one multiply
// stage, one rounding stage, a result sequencer and an output register.
// A new item enters every cycle while the pipeline is not stalled; the
// result sequencer emits one result per cycle while the output is not
// stalled, and holds an item, with new items waiting behind it, until its
// last result is out. Configuration is always accepted and must only be
// written while the block is idle.
module circle_point_and_derivatives_unit
    import cpd_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int DATA_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpd_in_if.sink    i_item,
    cpd_out_if.source o_result,
    cpd_cfg_if.sink   i_cfg
);

    localparam int NS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int PW = DATA_BITS + XW;   // product width
    localparam int CW = DATA_BITS + 1;    // rounded component width
    localparam int NW = DATA_BITS + 2;    // negated component width

    localparam logic signed [PW-1:0] ROUND_HALF =
        {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [NW-1:0] SAT_HI = {3'b000, {(DATA_BITS-1){1'b1}}};
    localparam logic signed [NW-1:0] SAT_LO = {3'b111, {(DATA_BITS-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [DATA_BITS-1:0] r_radius;
    logic                        r_explicit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= DATA_BITS'(256);
            r_explicit <= 1'b1;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_RADIUS) begin
                r_radius <= i_cfg.data;
            end
            if (i_cfg.index == REG_EXPLICIT_MODE) begin
                r_explicit <= i_cfg.data[0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage registers and advance enables
    // ------------------------------------------------------------------
    t_xy                r_x  [NS];
    t_xy                r_y  [NS];
    t_z                 r_z  [NS];
    logic [1:0]         r_q  [NS];
    logic [ORDER_W-1:0] r_mo [NS];
    logic               r_v  [NS];
    logic               w_en [NS];

    logic                   r_m_v;
    logic signed [PW-1:0]   r_m_pc;
    logic signed [PW-1:0]   r_m_ps;
    logic [1:0]             r_m_q;
    logic [ORDER_W-1:0]     r_m_mo;

    logic                   r_r_v;
    logic signed [CW-1:0]   r_r_c;
    logic signed [CW-1:0]   r_r_s;
    logic [1:0]             r_r_q;
    logic [ORDER_W-1:0]     r_r_mo;

    logic                   r_e_v;
    logic signed [CW-1:0]   r_e_c;
    logic signed [CW-1:0]   r_e_s;
    logic [1:0]             r_e_q;
    logic [ORDER_W-1:0]     r_e_n;
    logic [ORDER_W-1:0]     r_e_k;

    logic                        r_o_v;
    logic [ORDER_W-1:0]          r_o_order;
    logic signed [DATA_BITS-1:0] r_o_x;
    logic signed [DATA_BITS-1:0] r_o_y;
    logic                        r_o_last;

    logic w_o_load;
    logic w_e_last;
    logic w_en_e;
    logic w_en_r;
    logic w_en_m;

    // Emit one result whenever the output register frees up
    assign w_o_load = r_e_v && (!r_o_v || o_result.ready);
    assign w_e_last = (r_e_k == r_e_n);
    assign w_en_e   = !r_e_v || (w_o_load && w_e_last);
    assign w_en_r   = !r_r_v || w_en_e;
    assign w_en_m   = !r_m_v || w_en_r;

    assign i_item.ready = w_en[0];

    // ------------------------------------------------------------------
    // CORDIC rotation stages
    // ------------------------------------------------------------------
    logic [TURN_W-1:0] w_turn;
    assign w_turn = TURN_W'(i_item.angle) << (TURN_W - ANGLE_BITS);

    for (genvar i = 0; i < NS; i++) begin : g_stage
        t_xy                w_x;
        t_xy                w_y;
        t_z                 w_z;
        logic [1:0]         w_q;
        logic [ORDER_W-1:0] w_mo;
        logic               w_vin;
        t_xy                n_x;
        t_xy                n_y;
        t_z                 n_z;
        t_z                 w_atan;

        // Select stage inputs
        if (i == 0) begin : g_first
            assign w_x   = CORDIC_GAIN;
            assign w_y   = '0;
            assign w_z   = {3'b000, w_turn[FRAC_BITS-1:0]};
            assign w_q   = w_turn[TURN_W-1 -: 2];
            assign w_mo  = i_item.max_order;
            assign w_vin = i_item.valid;
        end else begin : g_next
            assign w_x   = r_x[i-1];
            assign w_y   = r_y[i-1];
            assign w_z   = r_z[i-1];
            assign w_q   = r_q[i-1];
            assign w_mo  = r_mo[i-1];
            assign w_vin = r_v[i-1];
        end

        // Advance when empty or when the next stage advances
        if (i == NS - 1) begin : g_en_tail
            assign w_en[i] = !r_v[i] || w_en_m;
        end else begin : g_en_body
            assign w_en[i] = !r_v[i] || w_en[i+1];
        end

        // Rotate toward zero residual angle
        assign w_atan = {1'b0, ATAN_TURN32[i]};
        always_comb begin
            if (!w_z[ZW-1]) begin
                n_x = w_x - (w_y >>> i);
                n_y = w_y + (w_x >>> i);
                n_z = w_z - w_atan;
            end else begin
                n_x = w_x + (w_y >>> i);
                n_y = w_y - (w_x >>> i);
                n_z = w_z + w_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (w_en[i]) begin
                r_v[i] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[i]) begin
                r_x[i]  <= n_x;
                r_y[i]  <= n_y;
                r_z[i]  <= n_z;
                r_q[i]  <= w_q;
                r_mo[i] <= w_mo;
            end
        end
    end

    // ------------------------------------------------------------------
    // Scale by radius
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (w_en_m) begin
            r_m_v <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_m) begin
            r_m_pc <= r_radius * r_x[NS-1];
            r_m_ps <= r_radius * r_y[NS-1];
            r_m_q  <= r_q[NS-1];
            r_m_mo <= r_mo[NS-1];
        end
    end

    // ------------------------------------------------------------------
    // Round half up and drop the Q30 fraction
    // ------------------------------------------------------------------
    logic signed [PW-1:0] w_rnd_c;
    logic signed [PW-1:0] w_rnd_s;

    assign w_rnd_c = r_m_pc + ROUND_HALF;
    assign w_rnd_s = r_m_ps + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else if (w_en_r) begin
            r_r_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_r) begin
            r_r_c  <= w_rnd_c[FRAC_BITS +: CW];
            r_r_s  <= w_rnd_s[FRAC_BITS +: CW];
            r_r_q  <= r_m_q;
            r_r_mo <= r_m_mo;
        end
    end

    // ------------------------------------------------------------------
    // Result sequencer, while the output is not stalled: one order per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_en_e) begin
            r_e_v <= r_r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_e) begin
            r_e_c <= r_r_c;
            r_e_s <= r_r_s;
            r_e_q <= r_r_q;
            r_e_n <= (r_explicit == DERIVATION_EXPLICIT) ? r_r_mo : '0;
            r_e_k <= '0;
        end else if (w_o_load) begin
            r_e_k <= r_e_k + 1'b1;
        end
    end

    // Turn by (q + k) quarter turns, then saturate
    logic [1:0]                  w_rot;
    logic signed [NW-1:0]        w_c;
    logic signed [NW-1:0]        w_s;
    logic signed [NW-1:0]        w_xr;
    logic signed [NW-1:0]        w_yr;
    logic signed [DATA_BITS-1:0] n_o_x;
    logic signed [DATA_BITS-1:0] n_o_y;

    assign w_rot = r_e_q + r_e_k[1:0];
    assign w_c   = NW'(r_e_c);
    assign w_s   = NW'(r_e_s);

    always_comb begin
        unique case (w_rot)
            2'd0: begin
                w_xr = w_c;
                w_yr = w_s;
            end
            2'd1: begin
                w_xr = -w_s;
                w_yr = w_c;
            end
            2'd2: begin
                w_xr = -w_c;
                w_yr = -w_s;
            end
            2'd3: begin
                w_xr = w_s;
                w_yr = -w_c;
            end
            default: begin
                w_xr = w_c;
                w_yr = w_s;
            end
        endcase
    end

    always_comb begin
        if (w_xr > SAT_HI) begin
            n_o_x = SAT_HI[DATA_BITS-1:0];
        end else if (w_xr < SAT_LO) begin
            n_o_x = SAT_LO[DATA_BITS-1:0];
        end else begin
            n_o_x = w_xr[DATA_BITS-1:0];
        end
        if (w_yr > SAT_HI) begin
            n_o_y = SAT_HI[DATA_BITS-1:0];
        end else if (w_yr < SAT_LO) begin
            n_o_y = SAT_LO[DATA_BITS-1:0];
        end else begin
            n_o_y = w_yr[DATA_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_o_load) begin
            r_o_v <= 1'b1;
        end else if (o_result.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_load) begin
            r_o_order <= r_e_k;
            r_o_x     <= n_o_x;
            r_o_y     <= n_o_y;
            r_o_last  <= w_e_last;
        end
    end

    assign o_result.valid   = r_o_v;
    assign o_result.order   = r_o_order;
    assign o_result.x_value = r_o_x;
    assign o_result.y_value = r_o_y;
    assign o_result.last    = r_o_last;

endmodule

// ===== design/cpd_checker.sv =====
// ----------------------------------------------------------------------------
// cpd_checker
// Port-level checks of the circle point and derivatives block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpd_checker
    import cpd_pkg::*;
#(
    parameter int DATA_BITS = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [ORDER_W-1:0]   i_order,
    input logic [DATA_BITS-1:0] i_x_value,
    input logic [DATA_BITS-1:0] i_y_value,
    input logic                 i_last
);

    localparam int PEND_W = 7;

    logic [ORDER_W+2*DATA_BITS:0] w_payload;
    logic [ORDER_W-1:0]           r_exp_order;
    logic [PEND_W-1:0]            r_pending;
    logic                         w_in_acc;
    logic                         w_out_acc;

    assign w_payload = {i_order, i_x_value, i_y_value, i_last};
    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // Track the expected order of the next result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_order <= '0;
        end else if (w_out_acc) begin
            r_exp_order <= i_last ? '0 : i_order + 1'b1;
        end
    end

    // Count items whose last result is still owed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + PEND_W'(w_in_acc) - PEND_W'(w_out_acc && i_last);
        end
    end

    `CPD_ASSERT_HOLD(a_out_valid_hold, i_clk, i_rst_n, i_out_valid, i_out_ready, i_out_valid, "result dropped while stalled")
    `CPD_ASSERT_HOLD(a_out_data_hold, i_clk, i_rst_n, i_out_valid, i_out_ready, w_payload, "result changed while stalled")
    `CPD_ASSERT(a_order_seq, i_clk, i_rst_n, i_out_valid |-> (i_order == r_exp_order), "result order out of sequence")
    `CPD_ASSERT(a_top_order_last, i_clk, i_rst_n, (i_out_valid && (i_order == '1)) |-> i_last, "highest order not marked last")
    `CPD_ASSERT(a_no_orphan, i_clk, i_rst_n, i_out_valid |-> (r_pending != '0), "result without an accepted item")

endmodule

bind circle_point_and_derivatives_unit cpd_checker #(
    .DATA_BITS (DATA_BITS)
) u_cpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_order     (o_result.order),
    .i_x_value   (o_result.x_value),
    .i_y_value   (o_result.y_value),
    .i_last      (o_result.last)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circle point and derivatives unit.
// ----------------------------------------------------------------------------
// A queue of angle requests feeds a clocked driver. For each accepted item a
// bit-exact CORDIC predictor works out the point and its derivative vectors
// and queues them. A clocked monitor checks every accepted result field by
// field against the oldest queued one. The run steps through directed corner
// items, then random items under several radius and mode settings, with the
// sender, the receiver, or both idling at random in separate phases.
module tb;
    import cpd_pkg::*;

    localparam int ANGLE_BITS    = 16;
    localparam int DATA_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = CORDIC_STAGES + 3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam longint GAIN_Q30  = 64'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn
    localparam longint ATAN_STEP [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
        652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct {
        logic [ANGLE_BITS-1:0] angle;
        logic [ORDER_W-1:0]    max_order;
    } t_angle_request;

    typedef struct {
        logic [ORDER_W-1:0]          order;
        logic signed [DATA_BITS-1:0] x_value;
        logic signed [DATA_BITS-1:0] y_value;
        logic                        last;
    } t_circle_vector;

    logic i_clk;
    logic i_rst_n;

    cpd_in_if  #(.ANGLE_BITS(ANGLE_BITS)) angle_ch ();
    cpd_out_if #(.DATA_BITS(DATA_BITS))   result_ch ();
    cpd_cfg_if #(.DATA_BITS(DATA_BITS))   cfg_ch ();

    circle_point_and_derivatives_unit #(
        .ANGLE_BITS   (ANGLE_BITS),
        .DATA_BITS    (DATA_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (angle_ch.sink),
        .o_result(result_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    t_angle_request              pending_angles[$];
    t_circle_vector              expected_vectors[$];
    logic signed [DATA_BITS-1:0] radius_setting;
    logic                        explicit_setting;
    int unsigned                 send_idle_pct;
    int unsigned                 recv_stall_pct;
    int unsigned                 mismatch_count = 0;
    int unsigned                 cycle_count = 0;

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Clamp to the signed output range
    function automatic logic signed [DATA_BITS-1:0] clamp_to_output(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DATA_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[DATA_BITS-1:0];
    endfunction

    // Rotation-mode CORDIC over the residual angle within one quadrant, Q30
    function automatic void cordic_cos_sin(input longint z_in, output longint cos_q30,
                                           output longint sin_q30);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = GAIN_Q30;
        y = 0;
        z = z_in;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        cos_q30 = x;
        sin_q30 = y;
    endfunction

    // Queue the point and its derivative vectors for one angle request
    function automatic void predict_circle_vectors(t_angle_request req);
        logic [31:0]    turn;
        int unsigned    quadrant;
        int unsigned    count;
        longint         r;
        longint         cz;
        longint         sz;
        longint         c;
        longint         s;
        longint         vx;
        longint         vy;
        t_circle_vector vec;
        turn     = 32'(req.angle) << (32 - ANGLE_BITS);
        quadrant = turn[31:30];
        cordic_cos_sin(longint'(turn[29:0]), cz, sz);
        r = longint'(radius_setting);
        c = (r * cz + (longint'(1) <<< 29)) >>> 30;
        s = (r * sz + (longint'(1) <<< 29)) >>> 30;
        count = (explicit_setting == DERIVATION_EXPLICIT) ? req.max_order + 1 : 1;
        for (int unsigned k = 0; k < count; k++) begin
            // Each order turns the vector one more quarter turn
            case ((quadrant + k) % 4)
                0: begin vx = c;  vy = s;  end
                1: begin vx = -s; vy = c;  end
                2: begin vx = -c; vy = -s; end
                default: begin vx = s; vy = -c; end
            endcase
            vec.order   = k[ORDER_W-1:0];
            vec.x_value = clamp_to_output(vx);
            vec.y_value = clamp_to_output(vy);
            vec.last    = (k + 1 == count);
            expected_vectors.push_back(vec);
        end
    endfunction

    // Angle driver: predict on acceptance, then present the next item or idle
    always @(posedge i_clk) begin
        t_angle_request req;
        if (!i_rst_n) begin
            angle_ch.valid <= 1'b0;
        end else begin
            if (angle_ch.valid && angle_ch.ready) begin
                req.angle     = angle_ch.angle;
                req.max_order = angle_ch.max_order;
                predict_circle_vectors(req);
            end
            if (!angle_ch.valid || angle_ch.ready) begin
                if (pending_angles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_angles.pop_front();
                    angle_ch.valid     <= 1'b1;
                    angle_ch.angle     <= req.angle;
                    angle_ch.max_order <= req.max_order;
                end else begin
                    angle_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stall at random, check each accepted item
    always @(posedge i_clk) begin
        t_circle_vector want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (result_ch.valid && result_ch.ready) begin
                if (expected_vectors.size() == 0) begin
                    $display("%0t: unexpected result order=%0d x=%0d y=%0d last=%0d",
                             $time, result_ch.order, result_ch.x_value,
                             result_ch.y_value, result_ch.last);
                    mismatch_count++;
                end else begin
                    want = expected_vectors.pop_front();
                    if (result_ch.order !== want.order) begin
                        $display("%0t: order expected %0d actual %0d",
                                 $time, want.order, result_ch.order);
                        mismatch_count++;
                    end
                    if (result_ch.x_value !== want.x_value) begin
                        $display("%0t: x_value expected %0d actual %0d (order %0d)",
                                 $time, want.x_value, result_ch.x_value, want.order);
                        mismatch_count++;
                    end
                    if (result_ch.y_value !== want.y_value) begin
                        $display("%0t: y_value expected %0d actual %0d (order %0d)",
                                 $time, want.y_value, result_ch.y_value, want.order);
                        mismatch_count++;
                    end
                    if (result_ch.last !== want.last) begin
                        $display("%0t: last expected %0d actual %0d (order %0d)",
                                 $time, want.last, result_ch.last, want.order);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Write one register and track it in the predictor's copy
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_BITS-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_RADIUS) radius_setting = value;
        else if (idx == REG_EXPLICIT_MODE) explicit_setting = value[0];
    endtask

    task automatic queue_angle(input logic [ANGLE_BITS-1:0] angle,
                               input logic [ORDER_W-1:0] max_order);
        t_angle_request req;
        req.angle     = angle;
        req.max_order = max_order;
        pending_angles.push_back(req);
    endtask

    // Hold until every queued item is accepted and every result has arrived
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_angles.size() != 0 || angle_ch.valid || expected_vectors.size() != 0);
    endtask

    // Random angles, partly clustered on the quadrant boundaries
    task automatic queue_random_angles(input int unsigned count);
        logic [ANGLE_BITS-1:0] angle;
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0)
                angle = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(4)) - 16'd2;
            else
                angle = 16'($urandom);
            queue_angle(angle, 3'($urandom_range(7)));
        end
    endtask

    // Stimulus
    initial begin
        logic [DATA_BITS-1:0] radius_pick;
        i_rst_n          = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_RADIUS;
        cfg_ch.data      = '0;
        radius_setting   = 16'sd256;
        explicit_setting = DERIVATION_EXPLICIT;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: quadrant edges, extreme angle, every order
        queue_angle(16'h0000, 3'd7);
        queue_angle(16'h4000, 3'd3);
        queue_angle(16'h8000, 3'd1);
        queue_angle(16'hC000, 3'd2);
        queue_angle(16'hFFFF, 3'd7);
        queue_angle(16'h0001, 3'd0);
        queue_angle(16'h2000, 3'd4);
        queue_angle(16'h3FFF, 3'd5);
        queue_angle(16'h6000, 3'd6);
        wait_drained();

        // Explicit mode off: only the point, whatever the order asked
        write_register(REG_EXPLICIT_MODE, '0);
        queue_angle(16'h1234, 3'd7);
        queue_angle(16'h0000, 3'd0);
        wait_drained();

        // Most negative radius: negation saturates
        write_register(REG_EXPLICIT_MODE, 16'(DERIVATION_EXPLICIT));
        write_register(REG_RADIUS, 16'h8000);
        queue_angle(16'h0000, 3'd3);
        queue_angle(16'h8000, 3'd3);
        queue_angle(16'h4000, 3'd3);
        wait_drained();

        // Largest positive radius
        write_register(REG_RADIUS, 16'h7FFF);
        queue_angle(16'h0000, 3'd3);
        queue_angle(16'hE000, 3'd7);
        wait_drained();

        // Radius -1.0: point opposite the angle
        write_register(REG_RADIUS, 16'hFF00);
        queue_angle(16'h2000, 3'd3);
        queue_angle(16'h0000, 3'd1);
        wait_drained();

        // Zero radius
        write_register(REG_RADIUS, 16'h0000);
        queue_angle(16'h5555, 3'd7);
        wait_drained();

        // Random items under each idling mode and two settings per mode
        for (int phase = 0; phase < 8; phase++) begin
            case (phase / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            case (phase)
                0: radius_pick = 16'h7FFF;
                1: radius_pick = 16'h8000;
                3: radius_pick = 16'h0100;
                4: radius_pick = 16'hFF00;
                6: radius_pick = 16'h0001;
                default: radius_pick = 16'($urandom);
            endcase
            write_register(REG_RADIUS, radius_pick);
            write_register(REG_EXPLICIT_MODE, 16'($urandom_range(3) != 0));
            queue_random_angles(13);
            wait_drained();
        end

        // Let any stray result surface
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
